@@ rtl/core/eb_isa_pkg.sv @@
// ----------------------------------------------------------------------------
// eb_isa_pkg
// Shared types and constants of the eight-bit execute unit: opcodes, status
// codes, storage sizes, flag and result records.
// ----------------------------------------------------------------------------
`default_nettype none

package eb_isa_pkg;

    localparam int unsigned REG_COUNT  = 64;
    localparam int unsigned DATA_DEPTH = 64;
    localparam int unsigned PC_SPAN    = 1024;

    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_LDI  = 4'd3;
    localparam logic [3:0] OP_BEQZ = 4'd4;
    localparam logic [3:0] OP_AND  = 4'd5;
    localparam logic [3:0] OP_OR   = 4'd6;
    localparam logic [3:0] OP_JR   = 4'd7;
    localparam logic [3:0] OP_SLC  = 4'd8;
    localparam logic [3:0] OP_SRC  = 4'd9;
    localparam logic [3:0] OP_LB   = 4'd10;
    localparam logic [3:0] OP_SB   = 4'd11;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ILLEGAL = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    typedef struct packed {
        logic c;
        logic v;
        logic n;
        logic s;
        logic z;
    } t_flags;

    typedef struct packed {
        logic [9:0] next_pc;
        logic       redirect;
        logic [1:0] status;
        logic       we;
        logic [7:0] wv;
        logic       store;
        t_flags     flags;
    } t_exec_res;

endpackage

`default_nettype wire

@@ rtl/core/eight_bit_isa_execute_unit.sv @@
// ----------------------------------------------------------------------------
// eight_bit_isa_execute_unit
// Execute unit of a small eight-bit processor: 64 registers, 64-byte data
// store, C/V/N/S/Z flags and the program counter.
//
//   channel | direction | signals
//   --------+-----------+-----------------------------------------------------
//   in      | sink      | i_valid, o_stall, i_opcode, i_first_reg,
//           |           | i_second_field
//   out     | source    | o_valid, i_stall, o_next_pc, o_redirect, o_status,
//           |           | o_write_enable, o_write_reg, o_write_value, o_flag_*
//
// One instruction per cycle when unstalled; a beat fills the operand stage,
// then the result register. Operands come from registered RAM reads at the
// input beat; a write by the instruction ahead at that same edge is bypassed.
// Reset: PC, flags and valid bits clear; entries never written read as zero.
// An output stall holds the result register and then the operand stage.
// ----------------------------------------------------------------------------
`default_nettype none

module eight_bit_isa_execute_unit
    import eb_isa_pkg::*;
#(
    parameter int unsigned IMEM_DEPTH = 1024
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [3:0] i_opcode,
    input  wire logic [5:0] i_first_reg,
    input  wire logic [5:0] i_second_field,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [9:0]      o_next_pc,
    output logic            o_redirect,
    output logic [1:0]      o_status,
    output logic            o_write_enable,
    output logic [5:0]      o_write_reg,
    output logic [7:0]      o_write_value,
    output logic            o_flag_c,
    output logic            o_flag_v,
    output logic            o_flag_n,
    output logic            o_flag_s,
    output logic            o_flag_z
);

    localparam int unsigned PC_LIMIT = (IMEM_DEPTH < PC_SPAN) ? IMEM_DEPTH : PC_SPAN;

    logic       acc;
    logic       s1_adv;
    logic       wr_now;
    logic       st_now;
    logic [7:0] a_val;
    logic [7:0] b_val;
    logic [7:0] d_val;
    logic [7:0] rf_a_q;
    logic [7:0] rf_b_q;
    logic [7:0] dm_q;
    t_exec_res  res;

    // operand stage
    logic       r_s1_valid, n_s1_valid;
    logic [3:0] r_s1_opcode;
    logic [5:0] r_s1_first_reg;
    logic [5:0] r_s1_second_field;
    logic       r_a_ram, r_b_ram, r_d_ram;
    logic [7:0] r_a_byp, r_b_byp, r_d_byp;

    // architectural state
    logic [REG_COUNT-1:0]  r_rf_vld;
    logic [DATA_DEPTH-1:0] r_dm_vld;
    logic [9:0]            r_pc;
    t_flags                r_flags;

    // result register
    logic       r_out_valid, n_out_valid;
    t_exec_res  r_out;
    logic [5:0] r_out_wreg;

    assign s1_adv  = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_adv;
    assign acc     = i_valid && !o_stall;
    assign wr_now  = s1_adv && res.we;
    assign st_now  = s1_adv && res.store;

    assign a_val = r_a_ram ? rf_a_q : r_a_byp;
    assign b_val = r_b_ram ? rf_b_q : r_b_byp;
    assign d_val = r_d_ram ? dm_q   : r_d_byp;

    eb_isa_ram #(.WIDTH(8), .DEPTH(REG_COUNT)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (wr_now),
        .i_waddr (r_s1_first_reg),
        .i_wdata (res.wv),
        .i_re    (acc),
        .i_raddr (i_first_reg),
        .o_rdata (rf_a_q)
    );

    eb_isa_ram #(.WIDTH(8), .DEPTH(REG_COUNT)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (wr_now),
        .i_waddr (r_s1_first_reg),
        .i_wdata (res.wv),
        .i_re    (acc),
        .i_raddr (i_second_field),
        .o_rdata (rf_b_q)
    );

    eb_isa_ram #(.WIDTH(8), .DEPTH(DATA_DEPTH)) u_dm (
        .i_clk   (i_clk),
        .i_we    (st_now),
        .i_waddr (r_s1_second_field),
        .i_wdata (a_val),
        .i_re    (acc),
        .i_raddr (i_second_field),
        .o_rdata (dm_q)
    );

    eb_isa_exec #(.PC_LIMIT(PC_LIMIT)) u_exec (
        .i_opcode       (r_s1_opcode),
        .i_second_field (r_s1_second_field),
        .i_a            (a_val),
        .i_b            (b_val),
        .i_ld           (d_val),
        .i_pc           (r_pc),
        .i_flags        (r_flags),
        .o_res          (res)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (acc) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_adv) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rf_vld    <= '0;
            r_dm_vld    <= '0;
            r_pc        <= '0;
            r_flags     <= '0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (wr_now) begin
                r_rf_vld[r_s1_first_reg] <= 1'b1;
            end
            if (st_now) begin
                r_dm_vld[r_s1_second_field] <= 1'b1;
            end
            if (s1_adv) begin
                r_pc    <= res.next_pc;
                r_flags <= res.flags;
            end
        end
    end

    // bypass the write of the instruction ahead when it lands on this beat
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_opcode       <= i_opcode;
            r_s1_first_reg    <= i_first_reg;
            r_s1_second_field <= i_second_field;
            r_a_ram <= !(wr_now && r_s1_first_reg == i_first_reg) && r_rf_vld[i_first_reg];
            r_a_byp <= (wr_now && r_s1_first_reg == i_first_reg) ? res.wv : 8'd0;
            r_b_ram <= !(wr_now && r_s1_first_reg == i_second_field)
                       && r_rf_vld[i_second_field];
            r_b_byp <= (wr_now && r_s1_first_reg == i_second_field) ? res.wv : 8'd0;
            r_d_ram <= !(st_now && r_s1_second_field == i_second_field)
                       && r_dm_vld[i_second_field];
            r_d_byp <= (st_now && r_s1_second_field == i_second_field) ? a_val : 8'd0;
        end
        if (s1_adv) begin
            r_out      <= res;
            r_out_wreg <= res.we ? r_s1_first_reg : 6'd0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_next_pc      = r_out.next_pc;
    assign o_redirect     = r_out.redirect;
    assign o_status       = r_out.status;
    assign o_write_enable = r_out.we;
    assign o_write_reg    = r_out_wreg;
    assign o_write_value  = r_out.wv;
    assign o_flag_c       = r_out.flags.c;
    assign o_flag_v       = r_out.flags.v;
    assign o_flag_n       = r_out.flags.n;
    assign o_flag_s       = r_out.flags.s;
    assign o_flag_z       = r_out.flags.z;

    a_illegal_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_ILLEGAL |-> !o_write_enable && !o_redirect)
        else $error("illegal opcode wrote a register or redirected");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_write_enable |-> o_write_reg == 6'd0 && o_write_value == 8'd0)
        else $error("write fields not cleared without a write");

    a_sign_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_flag_s == (o_flag_n ^ o_flag_v))
        else $error("S flag differs from N xor V");

    a_redirect_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_redirect |-> o_status == ST_OK)
        else $error("redirect with error status");

endmodule

`default_nettype wire

@@ rtl/core/eb_isa_ram.sv @@
// ----------------------------------------------------------------------------
// eb_isa_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module eb_isa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/eb_isa_exec.sv @@
// ----------------------------------------------------------------------------
// eb_isa_exec
// Combinational execute step: ALU, flags, branch and jump targets, PC range
// check and status for one decoded instruction.
// ----------------------------------------------------------------------------
`default_nettype none

module eb_isa_exec
    import eb_isa_pkg::*;
#(
    parameter int unsigned PC_LIMIT = 1024
) (
    input  wire logic [3:0] i_opcode,
    input  wire logic [5:0] i_second_field,
    input  wire logic [7:0] i_a,
    input  wire logic [7:0] i_b,
    input  wire logic [7:0] i_ld,
    input  wire logic [9:0] i_pc,
    input  wire t_flags     i_flags,
    output t_exec_res       o_res
);

    localparam logic [15:0] LIMIT = 16'(PC_LIMIT);

    logic [8:0]  sum;
    logic [7:0]  rslt;
    logic [15:0] prod;
    logic [15:0] rot_l;
    logic [15:0] rot_r;
    logic [15:0] target;
    logic        upd_nz;
    logic        jump;
    t_exec_res   res;

    always_comb begin
        sum    = {1'b0, i_a} + {1'b0, i_b};
        prod   = 16'(i_a) * 16'(i_b);
        rot_l  = {i_a, i_a} << i_second_field[2:0];
        rot_r  = {i_a, i_a} >> i_second_field[2:0];
        rslt   = '0;
        upd_nz = 1'b0;
        jump   = 1'b0;
        target = {6'b0, i_pc} + 16'd1;

        res          = '0;
        res.flags    = i_flags;
        res.status   = ST_OK;
        res.next_pc  = i_pc;

        case (i_opcode)
            OP_ADD: begin
                rslt         = sum[7:0];
                upd_nz       = 1'b1;
                res.flags.c  = sum[8];
                res.flags.v  = (i_a[7] == i_b[7]) && (rslt[7] != i_b[7]);
                res.we       = 1'b1;
            end
            OP_SUB: begin
                rslt         = i_a - i_b;
                upd_nz       = 1'b1;
                res.flags.v  = (i_a[7] != i_b[7]) && (rslt[7] == i_b[7]);
                res.we       = 1'b1;
            end
            OP_MUL: begin
                rslt   = prod[7:0];
                upd_nz = 1'b1;
                res.we = 1'b1;
            end
            OP_LDI: begin
                rslt   = {2'b0, i_second_field};
                res.we = 1'b1;
            end
            OP_BEQZ: begin
                if (i_a == 8'd0) begin
                    target = {6'b0, i_pc} + 16'd1 + {10'b0, i_second_field};
                    jump   = 1'b1;
                end
            end
            OP_AND: begin
                rslt   = i_a & i_b;
                upd_nz = 1'b1;
                res.we = 1'b1;
            end
            OP_OR: begin
                rslt   = i_a | i_b;
                upd_nz = 1'b1;
                res.we = 1'b1;
            end
            OP_JR: begin
                target = {i_a, i_b};
                jump   = 1'b1;
            end
            OP_SLC: begin
                rslt   = rot_l[15:8];
                upd_nz = 1'b1;
                res.we = 1'b1;
            end
            OP_SRC: begin
                rslt   = rot_r[7:0];
                upd_nz = 1'b1;
                res.we = 1'b1;
            end
            OP_LB: begin
                rslt   = i_ld;
                res.we = 1'b1;
            end
            OP_SB: begin
                res.store = 1'b1;
            end
            default: begin
                res.status = ST_ILLEGAL;
            end
        endcase

        if (upd_nz) begin
            res.flags.n = rslt[7];
            res.flags.z = (rslt == 8'd0);
            res.flags.s = rslt[7] ^ res.flags.v;
        end

        res.wv = res.we ? rslt : 8'd0;

        if (res.status == ST_OK) begin
            if (target >= LIMIT) begin
                res.status = ST_RANGE;
            end else begin
                res.next_pc  = target[9:0];
                res.redirect = jump;
            end
        end

        o_res = res;
    end

endmodule

`default_nettype wire
